/* rtl/aptp_pkg.sv */
package aptp_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = 4;
	localparam int TIME_W  = 32;
	localparam int PRIO_W  = 8;
	localparam int SCALE_W = 32;
	localparam int SCORE_W = 64;
	localparam int THR_W   = 36;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_ADMIT   = 2'd0;
	localparam cmd_t CMD_REQUEUE = 2'd1;
	localparam cmd_t CMD_REMOVE  = 2'd2;
	localparam cmd_t CMD_PICK    = 2'd3;

	// broadcast to every cell
	typedef struct packed {
		logic              upd;
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] now;
		logic [SCALE_W-1:0] scale;
	} cell_ctrl_t;

	// best-so-far handed from cell to cell
	typedef struct packed {
		logic               have;
		logic [SCORE_W-1:0] best;
		logic [SLOT_W-1:0]  win;
	} chain_t;

endpackage

/* rtl/aptp_cell.sv */
module aptp_cell #(
	parameter logic [3:0] IDX = 4'd0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aptp_pkg::cell_ctrl_t ctrl,
	input  aptp_pkg::chain_t    chain_in,
	output aptp_pkg::chain_t    chain_out
);
	import aptp_pkg::*;

	logic               ready_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [TIME_W-1:0]  last_q;
	logic [SCORE_W-1:0] score_q;
	logic [TIME_W:0]    diff;
	logic [PRIO_W+SCALE_W-1:0] prod;
	chain_t             chain_q;

	assign diff = {1'b0, ctrl.now} - {1'b0, last_q};
	assign prod = prio_q * ctrl.scale;

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			prio_q  <= '0;
			last_q  <= '0;
		end else if (ctrl.upd && ctrl.slot == IDX) begin
			case (ctrl.cmd)
				CMD_ADMIT: begin
					ready_q <= 1'b1;
					prio_q  <= ctrl.prio;
					last_q  <= '0;
				end
				CMD_REQUEUE: ready_q <= 1'b1;
				CMD_REMOVE:  ready_q <= 1'b0;
				CMD_PICK: begin
					ready_q <= 1'b0;
					last_q  <= ctrl.now;
				end
				default: ready_q <= ready_q;
			endcase
		end
	end

	// score wraps at 64 bits; a negative difference sign-extends
	always_ff @(posedge clk) begin
		score_q <= {{(SCORE_W-TIME_W-1){diff[TIME_W]}}, diff}
			+ {{(SCORE_W-PRIO_W-SCALE_W){1'b0}}, prod};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (ready_q && (!chain_in.have || score_q > chain_in.best)) begin
			chain_q.have <= 1'b1;
			chain_q.best <= score_q;
			chain_q.win  <= IDX;
		end else begin
			chain_q <= chain_in;
		end
	end

	assign chain_out = chain_q;

endmodule

/* rtl/aging_priority_task_picker_unit.sv */
// aging priority task picker
// input stream s_*: one beat is one command (admit, requeue, remove, pick)
// output stream m_*: exactly one beat per command, found and chosen_slot
// admit/requeue/remove beats give found=0, chosen_slot=0
// the slot table lives in a row of sixteen cells; each cell keeps one
// slot's ready bit, priority and last-pick time and computes its own score
// a pick first finds the decade scale by iterating a threshold times ten
// (one step per cycle while now is at or above the threshold), then lets the
// best-so-far record ripple through the cell row, one cell per cycle
// a result is loaded in ST_RESULT once the output register is free; a pick
// first passes ST_SCALE, ST_SCORE and the scan over the sixteen-cell row
// in ST_SCAN; the next beat can be taken in the cycle after the load
// one command is in flight at a time; a new beat is taken as soon as the
// previous result sits in the output register, even if it is not yet taken
// a stalled receiver holds the result; the next result then waits inside
// reset clears all ready bits, priorities and last-pick times at once
module aging_priority_task_picker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // command[1:0], slot[5:2], prio_value[13:6], now_ticks[45:14]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // found[0], chosen_slot[4:1]
);
	import aptp_pkg::*;

	localparam int CNT_W = $clog2(SLOTS + 2);

	typedef enum logic [2:0] {ST_IDLE, ST_SCALE, ST_SCORE, ST_SCAN, ST_RESULT} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [TIME_W-1:0]  now_q;
	logic [SCALE_W-1:0] scale_q;
	logic [THR_W-1:0]   thr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               found_q;
	logic [SLOT_W-1:0]  chosen_q;
	logic               out_free;
	cell_ctrl_t         ctrl;
	chain_t             chain [SLOTS+1];

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, chosen_q, found_q};

	// table update happens when the result is loaded
	always_comb begin
		ctrl.upd   = (state_q == ST_RESULT) && out_free &&
			(cmd_q != CMD_PICK || chain[SLOTS].have);
		ctrl.cmd   = cmd_q;
		ctrl.slot  = (cmd_q == CMD_PICK) ? chain[SLOTS].win : slot_q;
		ctrl.prio  = prio_q;
		ctrl.now   = now_q;
		ctrl.scale = scale_q;
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		aptp_cell #(.IDX(SLOT_W'(i))) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			chosen_q    <= '0;
			cmd_q       <= CMD_ADMIT;
			slot_q      <= '0;
			prio_q      <= '0;
			now_q       <= '0;
			scale_q     <= '0;
			thr_q       <= '0;
			cnt_q       <= '0;
		end else begin
			// in ST_RESULT the load below owns the valid flag
			if (out_valid_q && m_tready && state_q != ST_RESULT)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tdata[1:0];
						slot_q  <= s_tdata[5:2];
						prio_q  <= s_tdata[13:6];
						now_q   <= s_tdata[45:14];
						scale_q <= SCALE_W'(1);
						thr_q   <= THR_W'(1100);
						state_q <= (s_tdata[1:0] == CMD_PICK) ? ST_SCALE : ST_RESULT;
					end
				end
				// floor(now/100/10^k) > 10 exactly when now >= 1100*10^k
				ST_SCALE: begin
					if ({{(THR_W-TIME_W){1'b0}}, now_q} >= thr_q) begin
						thr_q   <= (thr_q << 3) + (thr_q << 1);
						scale_q <= (scale_q << 3) + (scale_q << 1);
					end else begin
						state_q <= ST_SCORE;
					end
				end
				ST_SCORE: begin
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_q == CNT_W'(SLOTS))
						state_q <= ST_RESULT;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (cmd_q == CMD_PICK && chain[SLOTS].have) begin
							found_q  <= 1'b1;
							chosen_q <= chain[SLOTS].win;
						end else begin
							found_q  <= 1'b0;
							chosen_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* tb/sv/aging_priority_task_picker_unit_tb.sv */
`timescale 1ns / 1ps

module aging_priority_task_picker_unit_tb;
	import aptp_pkg::*;

	typedef struct packed {
		logic [31:0]        now;
		logic [PRIO_W-1:0]  prio;
		logic [SLOT_W-1:0]  slot;
		cmd_t               cmd;
	} command_beat_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen;
		logic              found;
	} pick_result_t;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	// predictor copy of the slot table
	logic              mdl_ready [SLOTS];
	logic [PRIO_W-1:0] mdl_prio  [SLOTS];
	logic [TIME_W-1:0] mdl_last  [SLOTS];

	command_beat_t pending_cmds [$];
	pick_result_t  expected_results [$];
	int            err_count = 0;
	int            cycle_count = 0;
	int            gap_left;
	int            stall_left;
	bit            hold_sender;

	aging_priority_task_picker_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// decade scale: 1, times ten for each division of now/100 while above ten
	function automatic logic [63:0] decade_scale(input logic [TIME_W-1:0] now);
		logic [63:0] v;
		logic [63:0] sc;
		v  = now / 100;
		sc = 1;
		while (v > 10) begin
			v  = v / 10;
			sc = sc * 10;
		end
		return sc;
	endfunction

	// apply one command to the table and return its expected result beat
	function automatic pick_result_t apply_command(input command_beat_t c);
		pick_result_t r;
		logic [63:0]  sc;
		logic [63:0]  best;
		logic [63:0]  s;
		int           win;
		bit           have;
		r    = '0;
		have = 0;
		best = 0;
		win  = 0;
		if (c.cmd == CMD_PICK) begin
			sc = decade_scale(c.now);
			for (int i = 0; i < SLOTS; i++) begin
				if (mdl_ready[i]) begin
					s = {32'd0, c.now} - {32'd0, mdl_last[i]} + {56'd0, mdl_prio[i]} * sc;
					if (!have || s > best) begin
						best = s;
						win  = i;
						have = 1;
					end
				end
			end
			if (have) begin
				mdl_ready[win] = 1'b0;
				mdl_last[win]  = c.now;
				r.found  = 1'b1;
				r.chosen = win[SLOT_W-1:0];
			end
		end else if (c.cmd == CMD_ADMIT) begin
			mdl_ready[c.slot] = 1'b1;
			mdl_prio[c.slot]  = c.prio;
			mdl_last[c.slot]  = '0;
		end else if (c.cmd == CMD_REQUEUE) begin
			mdl_ready[c.slot] = 1'b1;
		end else begin
			mdl_ready[c.slot] = 1'b0;
		end
		return r;
	endfunction

	function automatic int random_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		err_count++;
	endtask

	function automatic command_beat_t make_cmd(input cmd_t cmd, input int slot,
			input int prio, input logic [31:0] now);
		command_beat_t c;
		c.cmd  = cmd;
		c.slot = slot[SLOT_W-1:0];
		c.prio = prio[PRIO_W-1:0];
		c.now  = now;
		return c;
	endfunction

	// random time base drifting upward, with some wild values and backward jumps
	function automatic logic [31:0] random_now(input logic [31:0] base);
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return base - $urandom_range(0, 500);
			2: return $urandom_range(0, 2000);
			default: return base + $urandom_range(0, 3000);
		endcase
	endfunction

	// driver: one beat in flight on the input side, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				s_tvalid <= 1'b0;
				gap_left <= random_gap();
			end else if (!s_tvalid) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (!hold_sender && pending_cmds.size() > 0) begin
					command_beat_t c;
					c = pending_cmds.pop_front();
					expected_results.push_back(apply_command(c));
					s_tdata  <= {2'b00, c};
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// monitor: random receiver stalls, compare each result beat in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				pick_result_t got;
				pick_result_t want;
				got = m_tdata[4:0];
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected beat", got, 0);
				end else begin
					want = expected_results.pop_front();
					if (got.found !== want.found)
						report_mismatch("found", got.found, want.found);
					if (got.chosen !== want.chosen)
						report_mismatch("chosen_slot", got.chosen, want.chosen);
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					stall_left <= random_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL aging_priority_task_picker_unit");
			$finish;
		end
	end

	initial begin
		logic [31:0] base;
		hold_sender = 0;
		for (int i = 0; i < SLOTS; i++) begin
			mdl_ready[i] = 1'b0;
			mdl_prio[i]  = '0;
			mdl_last[i]  = '0;
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pick, all-zero scores, extremes, each command
		pending_cmds.push_back(make_cmd(CMD_PICK, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_ADMIT, 5, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_ADMIT, 3, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_PICK, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_PICK, 15, 255, 32'hffff_ffff));
		pending_cmds.push_back(make_cmd(CMD_ADMIT, 15, 255, 32'hffff_ffff));
		pending_cmds.push_back(make_cmd(CMD_ADMIT, 0, 1, 0));
		pending_cmds.push_back(make_cmd(CMD_PICK, 0, 0, 32'hffff_ffff));
		pending_cmds.push_back(make_cmd(CMD_REQUEUE, 5, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_REQUEUE, 3, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_REMOVE, 0, 0, 0));
		// time going backwards against last-pick time
		pending_cmds.push_back(make_cmd(CMD_PICK, 0, 0, 10));
		pending_cmds.push_back(make_cmd(CMD_PICK, 0, 0, 1099));
		pending_cmds.push_back(make_cmd(CMD_REQUEUE, 15, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_PICK, 0, 0, 1100));
		pending_cmds.push_back(make_cmd(CMD_REMOVE, 15, 255, 32'hffff_ffff));
		pending_cmds.push_back(make_cmd(CMD_PICK, 0, 0, 123456));
		pending_cmds.push_back(make_cmd(CMD_PICK, 0, 0, 5));

		// pause until the directed part has fully drained
		wait (pending_cmds.size() == 0 && !s_tvalid);
		hold_sender = 1;
		wait (expected_results.size() == 0);
		hold_sender = 0;

		// random: mostly admits and picks on a rising clock, some noise
		base = $urandom_range(0, 5000);
		for (int n = 0; n < 1950; n++) begin
			int k;
			k = $urandom_range(0, 9);
			if (k < 3)
				pending_cmds.push_back(make_cmd(CMD_ADMIT, $urandom_range(0, 15),
					$urandom_range(0, 255), 32'($urandom)));
			else if (k < 4)
				pending_cmds.push_back(make_cmd(CMD_REQUEUE, $urandom_range(0, 15),
					$urandom_range(0, 255), 32'($urandom)));
			else if (k < 5)
				pending_cmds.push_back(make_cmd(CMD_REMOVE, $urandom_range(0, 15),
					$urandom_range(0, 255), 32'($urandom)));
			else begin
				base = random_now(base);
				pending_cmds.push_back(make_cmd(CMD_PICK, $urandom_range(0, 15),
					$urandom_range(0, 255), base));
			end
		end

		wait (pending_cmds.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (40) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0)
			$display("PASS aging_priority_task_picker_unit");
		else
			$display("FAIL aging_priority_task_picker_unit");
		$finish;
	end

endmodule

/* sim.f */
rtl/aptp_pkg.sv
rtl/aptp_cell.sv
rtl/aging_priority_task_picker_unit.sv
tb/sv/aging_priority_task_picker_unit_tb.sv
